// ----- design/sgr_pkg.sv -----
// shared constants for the stream group reverser
package sgr_pkg;

  localparam int VAL_W = 32;   // width of one stream value
  localparam int CFG_W = 5;    // width of the group size register

endpackage

// ----- design/sgr_cmdq.sv -----
// two-entry command queue between the front and back parts
module sgr_cmdq
  import sgr_pkg::*;
#(
  parameter int DATA_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              empty
);

  logic [DATA_W-1:0] slot_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign head_data = slot_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/sgr_front.sv -----
// front part: takes values, fills the current bank and closes groups
module sgr_front
  import sgr_pkg::*;
#(
  parameter int MAX_GROUP = 16,
  parameter int AW        = 4,
  parameter int CNT_W     = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CFG_W-1:0]        group_size,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic signed [VAL_W-1:0] in_item_value,
  input  logic                    in_is_final,
  input  logic                    cmd_full,
  output logic                    cmd_push,
  output logic [CNT_W+1:0]        cmd_data,
  output logic                    wr_en,
  output logic [AW:0]             wr_addr,
  output logic [VAL_W-1:0]        wr_data
);

  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             rev;
    logic             fin;
  } cmd_t;

  logic [AW-1:0]    fill_r, fill_nxt;
  logic             bank_r, bank_nxt;
  logic             accept;
  logic [CNT_W-1:0] n;
  logic [CMP_W-1:0] cfg_ext, max_ext, n_ext, size_eff;
  logic             trigger, close;
  cmd_t             cmd;

  assign in_full = cmd_full;
  assign accept  = in_push & ~cmd_full;

  // held count including the value arriving now
  assign n       = CNT_W'(fill_r) + CNT_W'(1);
  assign n_ext   = CMP_W'(n);
  assign cfg_ext = CMP_W'(group_size);
  assign max_ext = CMP_W'(MAX_GROUP);

  always_comb begin
    priority if (cfg_ext == '0) begin
      size_eff = CMP_W'(1);
    end else if (cfg_ext > max_ext) begin
      size_eff = max_ext;
    end else begin
      size_eff = cfg_ext;
    end
  end

  assign trigger = (n_ext >= size_eff);
  assign close   = trigger | in_is_final;

  always_comb begin
    cmd.count = n;
    cmd.rev   = trigger;
    cmd.fin   = in_is_final;
  end

  assign cmd_push = accept & close;
  assign cmd_data = cmd;
  assign wr_en    = accept;
  assign wr_addr  = {bank_r, fill_r};
  assign wr_data  = in_item_value;

  always_comb begin
    fill_nxt = fill_r;
    bank_nxt = bank_r;
    if (accept) begin
      if (close) begin
        fill_nxt = '0;
        bank_nxt = ~bank_r;
      end else begin
        fill_nxt = fill_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bank_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

// ----- design/sgr_back.sv -----
// back part: group memory, drain sequencer and result queue
module sgr_back
  import sgr_pkg::*;
#(
  parameter int AW    = 4,
  parameter int CNT_W = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [AW:0]             wr_addr,
  input  logic [VAL_W-1:0]        wr_data,
  input  logic                    cmd_empty,
  output logic                    cmd_pop,
  input  logic [CNT_W+1:0]        cmd_data,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_run_last,
  output logic                    out_sequence_last
);

  localparam int DEPTH    = 2 ** (AW + 1);
  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             rev;
    logic             fin;
  } cmd_t;

  logic [VAL_W-1:0] mem [DEPTH];

  cmd_t             cmd;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             rd_bank_r, rd_bank_nxt;
  logic             last;
  logic [CNT_W-1:0] idx;
  logic [AW:0]      rd_addr;
  logic             room, issue;

  logic [VAL_W-1:0] rd_data_r;
  logic             rd_vld_r;
  logic             rd_run_r, rd_seq_r;

  logic [VAL_W-1:0] oq_val_r [OQ_DEPTH];
  logic             oq_run_r [OQ_DEPTH];
  logic             oq_seq_r [OQ_DEPTH];
  logic [1:0]       oq_wr_r, oq_wr_nxt;
  logic [1:0]       oq_rd_r, oq_rd_nxt;
  logic [2:0]       oq_cnt_r, oq_cnt_nxt;
  logic             oq_pop;

  assign cmd  = cmd_t'(cmd_data);
  assign last = (k_r == cmd.count - CNT_W'(1));
  assign idx  = cmd.rev ? (cmd.count - CNT_W'(1) - k_r) : k_r;
  assign rd_addr = {rd_bank_r, idx[AW-1:0]};

  // leave space for the read already in flight
  assign room    = ({1'b0, oq_cnt_r} + {3'b000, rd_vld_r}) < 4'(OQ_DEPTH);
  assign issue   = ~cmd_empty & room;
  assign cmd_pop = issue & last;

  always_comb begin
    k_nxt       = k_r;
    rd_bank_nxt = rd_bank_r;
    if (issue) begin
      if (last) begin
        k_nxt       = '0;
        rd_bank_nxt = ~rd_bank_r;
      end else begin
        k_nxt = k_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[rd_addr];
      rd_run_r  <= last;
      rd_seq_r  <= last & cmd.fin;
    end
  end

  // result queue
  assign oq_pop    = out_pop & ~out_empty;
  assign out_empty = (oq_cnt_r == 3'd0);
  assign out_value         = oq_val_r[oq_rd_r];
  assign out_run_last      = oq_run_r[oq_rd_r];
  assign out_sequence_last = oq_seq_r[oq_rd_r];

  always_comb begin
    oq_wr_nxt  = rd_vld_r ? oq_wr_r + 2'd1 : oq_wr_r;
    oq_rd_nxt  = oq_pop ? oq_rd_r + 2'd1 : oq_rd_r;
    oq_cnt_nxt = oq_cnt_r + {2'b00, rd_vld_r} - {2'b00, oq_pop};
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      oq_val_r[oq_wr_r] <= rd_data_r;
      oq_run_r[oq_wr_r] <= rd_run_r;
      oq_seq_r[oq_wr_r] <= rd_seq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r       <= '0;
      rd_bank_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      oq_wr_r   <= 2'd0;
      oq_rd_r   <= 2'd0;
      oq_cnt_r  <= 3'd0;
    end else begin
      k_r       <= k_nxt;
      rd_bank_r <= rd_bank_nxt;
      rd_vld_r  <= issue;
      oq_wr_r   <= oq_wr_nxt;
      oq_rd_r   <= oq_rd_nxt;
      oq_cnt_r  <= oq_cnt_nxt;
    end
  end

endmodule

// ----- design/stream_group_reverser.sv -----
// top level of the stream group reverser
//
//   channel  ports                                        transaction when
//   cfg      cfg_wr_en, cfg_wr_data                       cfg_wr_en high
//   in       in_push, in_full, in_item_value, in_is_final in_push and not in_full
//   out      out_pop, out_empty, out_value, out_run_last,  out_pop and not out_empty
//            out_sequence_last
//
// one value is taken per cycle while not in_full; the back part emits one result per
// cycle from its memory read port while a command waits and the result queue has room
// two banks: one group fills while the previous one drains; in_full rises only
// when both banks hold closed groups not yet drained
// closed groups queue as commands; results pass a read register, then the result queue
// rst_n is synchronous; it empties both queues and sets the group size to 1
module stream_group_reverser
  import sgr_pkg::*;
#(
  parameter int MAX_GROUP = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic signed [VAL_W-1:0] in_item_value,
  input  logic                    in_is_final,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_run_last,
  output logic                    out_sequence_last
);

  localparam int AW    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int CMD_W = CNT_W + 2;

  logic [CFG_W-1:0] group_size_r, group_size_nxt;

  logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CMD_W-1:0] cmd_in, cmd_head;
  logic             wr_en;
  logic [AW:0]      wr_addr;
  logic [VAL_W-1:0] wr_data;

  assign group_size_nxt = cfg_wr_en ? cfg_wr_data : group_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= CFG_W'(1);
    end else begin
      group_size_r <= group_size_nxt;
    end
  end

  sgr_front #(
    .MAX_GROUP (MAX_GROUP),
    .AW        (AW),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .group_size    (group_size_r),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_item_value (in_item_value),
    .in_is_final   (in_is_final),
    .cmd_full      (cmd_full),
    .cmd_push      (cmd_push),
    .cmd_data      (cmd_in),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  sgr_cmdq #(
    .DATA_W (CMD_W)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .head_data (cmd_head),
    .empty     (cmd_empty)
  );

  sgr_back #(
    .AW    (AW),
    .CNT_W (CNT_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .cmd_empty         (cmd_empty),
    .cmd_pop           (cmd_pop),
    .cmd_data          (cmd_head),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_value         (out_value),
    .out_run_last      (out_run_last),
    .out_sequence_last (out_sequence_last)
  );

endmodule

// ----- sim/stream_group_reverser_test.sv -----
// testbench for the stream group reverser: group reversal, tails, size changes, random traffic
`timescale 1ns / 1ps

import sgr_pkg::*;

localparam int GROUP_LIMIT = 16;

typedef struct packed {
  logic [VAL_W-1:0] value;
  logic             run_last;
  logic             seq_last;
} reordered_t;

class reorder_scoreboard;
  logic [VAL_W-1:0] held[GROUP_LIMIT];
  int unsigned      held_count;
  logic [CFG_W-1:0] group_size;
  reordered_t       expected_q[$];
  int unsigned      errors;

  function new();
    held_count = 0;
    group_size = CFG_W'(1);
    errors = 0;
  endfunction

  // zero acts as one, anything past the buffer depth saturates
  function int unsigned active_size();
    int unsigned s;
    s = group_size;
    if (s < 1) s = 1;
    if (s > GROUP_LIMIT) s = GROUP_LIMIT;
    return s;
  endfunction

  function void set_group_size(logic [CFG_W-1:0] s);
    group_size = s;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void note_input(logic [VAL_W-1:0] v, logic fin);
    reordered_t  r;
    int unsigned n;
    bit          reversed;
    if (held_count < GROUP_LIMIT) begin
      held[held_count] = v;
      held_count++;
    end
    n = held_count;
    reversed = (n >= active_size());
    if (reversed || fin) begin
      for (int unsigned k = 0; k < n; k++) begin
        r.value = reversed ? held[n - 1 - k] : held[k];
        r.run_last = (k + 1 == n);
        r.seq_last = r.run_last && fin;
        expected_q.push_back(r);
      end
      held_count = 0;
    end
  endfunction

  function void check_result(logic [VAL_W-1:0] v, logic run_last, logic seq_last);
    reordered_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: value %0d run_last %0b sequence_last %0b",
                 $signed(v), run_last, seq_last);
      return;
    end
    want = expected_q.pop_front();
    if (want.value !== v || want.run_last !== run_last || want.seq_last !== seq_last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected value %0d run_last %0b sequence_last %0b, got %0d %0b %0b",
                 $signed(want.value), want.run_last, want.seq_last,
                 $signed(v), run_last, seq_last);
    end
  endfunction
endclass

module stream_group_reverser_test;

  localparam int DRAIN_CYCLES = 10;
  localparam longint TIMEOUT_NS = 4_000_000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]        cfg_wr_data = '0;
  logic                    in_push = 1'b0;
  logic                    in_full;
  logic signed [VAL_W-1:0] in_item_value = '0;
  logic                    in_is_final = 1'b0;
  logic                    out_empty;
  logic                    out_pop = 1'b0;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_run_last;
  logic                    out_sequence_last;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  reorder_scoreboard sb;

  stream_group_reverser #(.MAX_GROUP(GROUP_LIMIT)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_item_value     (in_item_value),
    .in_is_final       (in_is_final),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_value         (out_value),
    .out_run_last      (out_run_last),
    .out_sequence_last (out_sequence_last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // both channels sampled before this edge's updates land
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full)
        sb.note_input(in_item_value, in_is_final);
      if (out_pop && !out_empty)
        sb.check_result(out_value, out_run_last, out_sequence_last);
    end
  end

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input logic signed [VAL_W-1:0] v, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item_value <= v;
    in_is_final <= fin;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // extra edge first so the monitor has seen the last transaction
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_group_size(input logic [CFG_W-1:0] s);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_group_size(s);
  endtask

  // mostly complete sequences, some with random final flags; the last one may be cut short
  task automatic run_segment(input int unsigned n_items);
    int unsigned left;
    int unsigned len;
    bit          clean;
    bit          cut;
    logic        fin;
    left = n_items;
    while (left > 0) begin
      clean = ($urandom_range(99) < 80);
      len = $urandom_range(1, 2 * sb.active_size() + 3);
      cut = (len > left);
      if (cut) len = left;
      for (int unsigned k = 0; k < len; k++) begin
        if (clean) fin = (k + 1 == len) && !cut;
        else fin = ($urandom_range(3) == 0);
        push_item(random_value(), fin);
      end
      left -= len;
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned seg_sizes[9];
    int unsigned budget;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // group size one at reset: straight pass-through
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(32'sh8000_0000, 1'b1);
    push_item('0, 1'b0);
    wait_drained();
    write_group_size(5'd4);
    // full group ending on the final transaction
    push_item(1, 1'b0);
    push_item(2, 1'b0);
    push_item(3, 1'b0);
    push_item(-1, 1'b1);
    // short tail keeps its order
    push_item(10, 1'b0);
    push_item(11, 1'b0);
    push_item(12, 1'b1);
    // three held, then the size drops below the fill
    push_item(20, 1'b0);
    push_item(21, 1'b0);
    push_item(22, 1'b0);
    wait_drained();
    write_group_size(5'd2);
    push_item(23, 1'b0);
    wait_drained();
    write_group_size(5'd0);
    push_item(-5, 1'b0);
    push_item(6, 1'b1);
    wait_drained();

    seg_sizes = '{1, 16, 5, 31, 0, 2, 17, 8, 3};
    seg_sizes[2] = $urandom_range(1, GROUP_LIMIT);
    seg_sizes[8] = $urandom_range(1, GROUP_LIMIT);
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 3; s++) begin
        write_group_size(CFG_W'(seg_sizes[ph * 3 + s]));
        budget = (sb.active_size() >= 8) ? 18 : 8;
        run_segment(budget);
        wait_drained();
      end
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
